// ===== rtl/arpc_pkg.sv =====
// Package for the ARP cache: item and result structs, state encoding and
// protocol constants. No dependencies.
`default_nettype none

package arpc_pkg;

  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;
  localparam int unsigned LenW = 11;
  localparam int unsigned OpW  = 16;

  // Shortest ARP payload that is learned from.
  localparam logic [LenW-1:0] MinArpLen = 11'd28;
  localparam logic [OpW-1:0]  OpRequest = 16'd1;

  localparam logic FuncLearn  = 1'b0;
  localparam logic FuncLookup = 1'b1;

  typedef struct packed {
    logic            func;
    logic [LenW-1:0] frame_length;
    logic [OpW-1:0]  opcode;
    logic [IpW-1:0]  peer_ip;
    logic [MacW-1:0] peer_mac;
    logic [IpW-1:0]  dest_ip;
  } arpc_in_t;

  typedef struct packed {
    logic            hit;
    logic [MacW-1:0] found_mac;
    logic            reply_needed;
    logic            accepted;
  } arpc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } arpc_state_e;

endpackage

`default_nettype wire

// ===== rtl/arpc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module arpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/arp_cache_learn_lookup.sv =====
// ARP cache: a lookup or a learn item (length 28 or more) scans the table one entry
// per cycle through the entry RAM read port; the block takes no new item until
// the result has been loaded. A short learn item skips the scan and is dropped,
// with accepted clear in its result.
// Reset clears all valid marks and own_ip at once; no clearing pass is needed.
`default_nettype none

module arp_cache_learn_lookup #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  arpc_pkg::arpc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output arpc_pkg::arpc_out_t out_data_o
);

  import arpc_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = IpW + MacW;

  arpc_state_e state_q, state_d;

  arpc_in_t        item_q, item_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic [IW-1:0]   cmp_idx_q, cmp_idx_d;
  logic            found_q, found_d;
  logic [IW-1:0]   found_idx_q, found_idx_d;
  logic [MacW-1:0] found_mac_q, found_mac_d;
  logic            free_q, free_d;
  logic [IW-1:0]   free_idx_q, free_idx_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IpW-1:0]  own_ip_q;
  logic            out_valid_q, out_valid_d;
  arpc_out_t       res_q, res_d;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_rdata;
  logic [IpW-1:0]  rd_ip;
  logic [MacW-1:0] rd_mac;

  logic accept, in_short, item_short, scan_done, load_res, match, free_hit;

  arpc_ram #(
    .Width(EW),
    .Depth(ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({item_q.peer_ip, item_q.peer_mac}),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_ip  = ram_rdata[EW-1:MacW];
  assign rd_mac = ram_rdata[MacW-1:0];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  assign in_short   = (in_data_i.func == FuncLearn) && (in_data_i.frame_length < MinArpLen);
  assign item_short = (item_q.func == FuncLearn) && (item_q.frame_length < MinArpLen);
  assign scan_done  = (cnt_q == CW'(ENTRIES));
  assign load_res   = !out_valid_q || !out_stall_i;

  // The read issued last cycle is compared now; only the first hit counts.
  assign match    = pend_q && valid_q[cmp_idx_q] && (rd_ip == item_q.peer_ip) && !found_q;
  assign free_hit = pend_q && !valid_q[cmp_idx_q] && !free_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = in_short ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_res) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_d      = item_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_mac_d = found_mac_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    valid_d     = valid_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = found_q ? found_idx_q : (free_q ? free_idx_q : '0);

    if (match) begin
      found_d     = 1'b1;
      found_idx_d = cmp_idx_q;
      found_mac_d = rd_mac;
    end
    if (free_hit) begin
      free_d     = 1'b1;
      free_idx_d = cmp_idx_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d  = in_data_i;
          cnt_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          free_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (!scan_done) begin
          cnt_d     = cnt_q + CW'(1);
          pend_d    = 1'b1;
          cmp_idx_d = cnt_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_FINISH: begin
        if (load_res) begin
          out_valid_d = 1'b1;
          res_d       = '0;
          if (item_q.func == FuncLookup) begin
            res_d.hit       = found_q;
            res_d.found_mac = found_q ? found_mac_q : '0;
            res_d.accepted  = 1'b1;
          end else if (!item_short) begin
            ram_we             = 1'b1;
            valid_d[ram_waddr] = 1'b1;
            res_d.accepted     = 1'b1;
            res_d.reply_needed = (item_q.opcode == OpRequest) &&
                                 (item_q.dest_ip == own_ip_q) && (own_ip_q != '0);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      own_ip_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      free_q      <= free_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        own_ip_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    cmp_idx_q   <= cmp_idx_d;
    found_idx_q <= found_idx_d;
    found_mac_q <= found_mac_d;
    free_idx_q  <= free_idx_d;
    res_q       <= res_d;
  end

endmodule

`default_nettype wire

// ===== rtl/arpc_checker.sv =====
// Port-level checks for the ARP cache input and result channels, bound to the top level.
// Depends on arpc_pkg and arp_cache_learn_lookup.
`default_nettype none

module arpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input arpc_pkg::arpc_out_t out_data_o
);

  import arpc_pkg::*;

  // An input transfer keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // A stalled result transfer keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A hit only comes from a lookup, which never owes a reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.accepted && !out_data_o.reply_needed)
    else $error("hit result has inconsistent flags");

  // A miss or a learn result carries no MAC.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.found_mac == '0)
    else $error("MAC reported without a hit");

  // A reply is only owed for a learn item that was stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reply_needed |-> out_data_o.accepted)
    else $error("reply flagged for a dropped item");

endmodule

bind arp_cache_learn_lookup arpc_checker u_arpc_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for arp_cache_learn_lookup: directed learn and lookup cases,
// then random traffic under sender and receiver idling. Depends on arpc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import arpc_pkg::*;

  localparam int Entries = 16;
  localparam int PoolSize = 20;
  localparam int CycleLimit = 500_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  arpc_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  arpc_out_t out_data_o;

  // Our own copy of the cache and the host address.
  bit cache_valid [Entries];
  logic [IpW-1:0] cache_ip [Entries];
  logic [MacW-1:0] cache_mac [Entries];
  logic [IpW-1:0] host_ip = '0;

  arpc_out_t pending_results [$];
  logic [IpW-1:0] ip_pool [PoolSize];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int error_count = 0;
  int sent_count = 0;
  int result_count = 0;
  int hit_count = 0;
  int reply_count = 0;
  int dropped_count = 0;
  int host_ip_writes = 0;

  arp_cache_learn_lookup #(
    .ENTRIES(Entries)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_results.size());
      $display("arp_cache_learn_lookup regression: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic arpc_out_t predict_arp_result(arpc_in_t item);
    arpc_out_t res;
    int match;
    int slot;
    res = '0;
    match = -1;
    for (int k = 0; k < Entries; k++) begin
      if (match < 0 && cache_valid[k] && cache_ip[k] == item.peer_ip) match = k;
    end
    if (item.func == FuncLookup) begin
      res.accepted = 1'b1;
      if (match >= 0) begin
        res.hit = 1'b1;
        res.found_mac = cache_mac[match];
      end
    end else if (item.frame_length >= MinArpLen) begin
      res.accepted = 1'b1;
      if (match >= 0) begin
        cache_mac[match] = item.peer_mac;
      end else begin
        // Lowest free entry wins; a full table falls back to entry 0.
        slot = 0;
        for (int k = Entries - 1; k >= 0; k--) begin
          if (!cache_valid[k]) slot = k;
        end
        cache_ip[slot] = item.peer_ip;
        cache_mac[slot] = item.peer_mac;
        cache_valid[slot] = 1'b1;
      end
      res.reply_needed = (item.opcode == OpRequest) && (item.dest_ip == host_ip) &&
                         (host_ip != '0);
    end
    return res;
  endfunction

  function automatic arpc_in_t arp_item(logic func, logic [LenW-1:0] len,
                                        logic [OpW-1:0] op, logic [IpW-1:0] pip,
                                        logic [MacW-1:0] mac, logic [IpW-1:0] tip);
    arpc_in_t item;
    item.func = func;
    item.frame_length = len;
    item.opcode = op;
    item.peer_ip = pip;
    item.peer_mac = mac;
    item.dest_ip = tip;
    return item;
  endfunction

  function automatic arpc_in_t random_arp_item();
    arpc_in_t item;
    int unsigned pick;
    item.func = ($urandom_range(99) < 40) ? FuncLookup : FuncLearn;
    pick = $urandom_range(99);
    if (pick < 80) item.frame_length = 11'($urandom_range(1500, 28));
    else if (pick < 90) item.frame_length = 11'($urandom_range(27, 0));
    else item.frame_length = 11'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) item.opcode = OpRequest;
    else if (pick < 70) item.opcode = 16'd2;
    else item.opcode = 16'($urandom);
    // Most addresses come from a small pool so that the table fills and hits occur.
    item.peer_ip = ($urandom_range(99) < 85) ? ip_pool[$urandom_range(PoolSize - 1)]
                                               : $urandom;
    item.peer_mac = {16'($urandom), 32'($urandom)};
    pick = $urandom_range(99);
    if (pick < 50) item.dest_ip = host_ip;
    else if (pick < 70) item.dest_ip = ip_pool[$urandom_range(PoolSize - 1)];
    else item.dest_ip = $urandom;
    return item;
  endfunction

  task automatic send_item(arpc_in_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_arp_result(item));
    sent_count++;
  endtask

  // Hold the sender off until every predicted result has been checked.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_host_ip(logic [IpW-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    host_ip = value;
    host_ip_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    arpc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, out_data_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.hit !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, out_data_o.hit);
          error_count++;
        end
        if (out_data_o.found_mac !== want.found_mac) begin
          $display("%0t: found_mac expected %h actual %h", $time, want.found_mac,
                   out_data_o.found_mac);
          error_count++;
        end
        if (out_data_o.reply_needed !== want.reply_needed) begin
          $display("%0t: reply_needed expected %b actual %b", $time, want.reply_needed,
                   out_data_o.reply_needed);
          error_count++;
        end
        if (out_data_o.accepted !== want.accepted) begin
          $display("%0t: accepted expected %b actual %b", $time, want.accepted,
                   out_data_o.accepted);
          error_count++;
        end
        if (want.hit) hit_count++;
        if (want.reply_needed) reply_count++;
        if (!want.accepted) dropped_count++;
      end
    end
  end

  // Lookups on an empty table miss; a request to address zero owes no reply.
  task automatic test_empty_table();
    send_item(arp_item(FuncLookup, '0, '0, 32'h0, '0, '0));
    send_item(arp_item(FuncLookup, '0, '0, 32'hFFFF_FFFF, '0, '0));
    send_item(arp_item(FuncLearn, 11'd28, OpRequest, 32'hC0A8_0001, 48'h0011_2233_4455,
                       32'h0));
    send_item(arp_item(FuncLookup, '0, '0, 32'hC0A8_0001, '0, '0));
  endtask

  task automatic test_short_packets();
    write_host_ip(32'h0);
    send_item(arp_item(FuncLearn, 11'd0, OpRequest, 32'hC0A8_0002, 48'hAAAA_0000_0002,
                       32'h0));
    send_item(arp_item(FuncLearn, 11'd27, OpRequest, 32'hC0A8_0002, 48'hAAAA_0000_0002,
                       32'h0));
    send_item(arp_item(FuncLookup, '0, '0, 32'hC0A8_0002, '0, '0));
  endtask

  task automatic test_field_extremes();
    write_host_ip(32'hFFFF_FFFF);
    send_item(arp_item(FuncLearn, 11'd2047, OpRequest, 32'h0, 48'hFFFF_FFFF_FFFF,
                       32'hFFFF_FFFF));
    send_item(arp_item(FuncLearn, 11'd1500, 16'hFFFF, 32'hFFFF_FFFF, 48'h0,
                       32'hFFFF_FFFF));
    send_item(arp_item(FuncLearn, 11'd28, 16'h0, 32'h0A00_0003, 48'h1234_5678_9ABC,
                       32'hFFFF_FFFF));
    send_item(arp_item(FuncLearn, 11'd64, OpRequest, 32'h0A00_0004, 48'h5555_AAAA_5555,
                       32'hFFFF_FFFE));
    // A known address only has its MAC replaced.
    send_item(arp_item(FuncLearn, 11'd46, 16'd2, 32'hC0A8_0001, 48'hFEDC_BA98_7654,
                       32'h0));
    send_item(arp_item(FuncLookup, '0, '0, 32'hC0A8_0001, '0, '0));
    send_item(arp_item(FuncLookup, '0, '0, 32'h0, '0, '0));
  endtask

  // Fill every free entry, then one more address takes over entry 0.
  task automatic test_table_full();
    write_host_ip(32'h0A00_0001);
    for (int k = 0; k < 11; k++) begin
      send_item(arp_item(FuncLearn, 11'd28, OpRequest, 32'h0A01_0000 + k,
                         {16'hBEEF, 32'(k)}, 32'h0A00_0001));
    end
    send_item(arp_item(FuncLearn, 11'd28, 16'd2, 32'h0A02_0000, 48'hCAFE_0000_0001, '0));
    send_item(arp_item(FuncLookup, '0, '0, 32'hC0A8_0001, '0, '0));
    send_item(arp_item(FuncLookup, '0, '0, 32'h0A02_0000, '0, '0));
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    int unsigned pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 149) begin
        pick = $urandom_range(3);
        case (pick)
          0: write_host_ip(32'h0);
          1: write_host_ip(32'hFFFF_FFFF);
          2: write_host_ip(ip_pool[$urandom_range(PoolSize - 1)]);
          default: write_host_ip($urandom);
        endcase
      end
      send_item(random_arp_item());
    end
    drain_results();
  endtask

  initial begin
    ip_pool[0] = 32'h0;
    ip_pool[1] = 32'hFFFF_FFFF;
    ip_pool[2] = 32'h0A00_0001;
    for (int k = 3; k < PoolSize; k++) ip_pool[k] = $urandom;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_short_packets();
    test_field_extremes();
    test_table_full();
    test_random_traffic(9, 45, 450);
    test_random_traffic(45, 9, 450);
    test_random_traffic(0, 0, 450);

    drain_results();
    recv_idle_pct = 0;
    repeat (Entries + 4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      error_count++;
    end

    $display("Sent %0d learn and lookup transfers and checked %0d results.", sent_count,
             result_count);
    $display("Saw %0d lookup hits, %0d owed replies, %0d short packets, %0d own_ip writes.",
             hit_count, reply_count, dropped_count, host_ip_writes);
    if (error_count == 0) begin
      $display("arp_cache_learn_lookup regression: pass");
    end else begin
      $display("arp_cache_learn_lookup regression: fail");
    end
    $finish;
  end

endmodule
